/* hdl/efla_pkg.sv */
// Shared constants for the extent free-list allocator: field widths, request modes,
// result status codes and the default sizing of the list.
// No dependencies.
package efla_pkg;

  localparam int LIST_DEPTH_DEF  = 64;
  localparam int EXTENT_BITS_DEF = 62;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

/* hdl/extent_free_list_allocator.sv */
// Top level of the extent free-list allocator: sequencer, free-list memory and output register.
// Depends on efla_pkg.

// The block keeps up to LIST_DEPTH free extents, ordered by offset, in one synchronous
// memory with a registered read port, plus an extent counter. Every request goes
// through a sequencer that reads the list one entry per cycle and then edits it in place.
// A request is accepted only while the sequencer is idle; its single result waits in an
// output register, so the next request can be taken while that result is still pending.
// A request that needs no list access (zero sizes, resize to the same size, mode 3) goes
// straight to the output register. Every other request first scans the whole list and
// may then carve or merge. When an entry has to be removed or inserted, the entries above
// it move by one place at one per cycle. A grow that relocates the block scans the list
// twice and may shift it twice, so it is the slowest case. There is no clearing pass
// after reset: the counter starts at zero and only entries below it are ever read.
module extent_free_list_allocator
  import efla_pkg::*;
#(
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF,
  localparam int IN_W  = ((3 * EXTENT_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * EXTENT_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata, from bit 0 up: block_offset, block_size, request_size, zero padding.
  input  logic [IN_W-1:0]     s_tdata,
  // s_tuser: mode.
  input  logic [MODE_W-1:0]   s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata, from bit 0 up: granted_offset, granted_size, zero padding.
  output logic [OUT_W-1:0]    m_tdata,
  // m_tuser: status.
  output logic [STATUS_W-1:0] m_tuser
);

  localparam int EB = EXTENT_BITS;
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef struct packed {
    logic [EB-1:0] off;
    logic [EB-1:0] sz;
  } ent_t;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_TOUCH = 4'd3;
  localparam logic [3:0] S_ACT   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_CARVE = 4'd6;
  localparam logic [3:0] S_SHDN  = 4'd7;
  localparam logic [3:0] S_SHUP  = 4'd8;
  localparam logic [3:0] S_PUT   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // Operation in progress. OP_RELOC is the second half of a relocating grow, where the old
  // block is returned to the list after the new one has been carved.
  localparam logic [2:0] OP_INS    = 3'd0;
  localparam logic [2:0] OP_SHRINK = 3'd1;
  localparam logic [2:0] OP_ALLOC  = 3'd2;
  localparam logic [2:0] OP_GROW   = 3'd3;
  localparam logic [2:0] OP_RELOC  = 3'd4;

  function automatic logic [EB-1:0] sat_add(input logic [EB-1:0] a, input logic [EB-1:0] b);
    logic [EB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EB] ? {EB{1'b1}} : s[EB-1:0];
  endfunction

  // Input fields.
  logic [EB-1:0]     in_off;
  logic [EB-1:0]     in_sz;
  logic [EB-1:0]     in_req;
  logic [MODE_W-1:0] in_mode;

  assign in_off  = s_tdata[EB-1:0];
  assign in_sz   = s_tdata[2*EB-1:EB];
  assign in_req  = s_tdata[3*EB-1:2*EB];
  assign in_mode = s_tuser;

  // Control and working registers.
  logic [3:0]    state;
  logic [3:0]    done_next;
  logic [2:0]    op;
  logic [CW-1:0] count;
  logic [EB-1:0] blk_off;
  logic [EB-1:0] blk_sz;
  logic [EB-1:0] req;
  logic [EB-1:0] inc;
  logic [EB-1:0] key_off;
  logic [EB-1:0] key_sz;
  logic [EB-1:0] key_end;
  logic [CW-1:0] scan_ptr;
  logic          found;
  logic [CW-1:0] p;
  ent_t          prev;
  ent_t          nxt;
  logic          best_found;
  logic [IW-1:0] best_idx;
  ent_t          best;
  logic          tp;
  logic          tn;
  logic          gfit;
  logic [EB-1:0] sum_pk;
  logic [EB-1:0] sum_kn;
  logic [IW-1:0] c_idx;
  logic [EB-1:0] c_off;
  logic [EB-1:0] c_sz;
  logic [EB-1:0] c_amt;
  logic [CW-1:0] sh_ptr;
  logic [EB-1:0] res_off;
  logic [EB-1:0] res_sz;
  logic [STATUS_W-1:0] res_st;
  logic [EB-1:0] out_off;
  logic [EB-1:0] out_sz;
  logic [STATUS_W-1:0] out_st;

  // Memory and its read pipeline.
  ent_t          mem [LIST_DEPTH];
  ent_t          rd_data;
  logic [IW-1:0] rd_idx;
  logic          rd_live;
  logic          mem_re;
  logic [IW-1:0] mem_ra;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  ent_t          mem_wd;

  logic          full;
  logic          ins_op;
  logic [CW-1:0] p_dec;
  logic [CW-1:0] sh_dec;
  logic [EB-1:0] prev_end;
  logic [EB-1:0] sum_pn;

  assign full     = (count == CW'(LIST_DEPTH));
  assign ins_op   = (op == OP_INS) || (op == OP_SHRINK) || (op == OP_RELOC);
  assign p_dec    = p - 1'b1;
  assign sh_dec   = sh_ptr - 1'b1;
  assign prev_end = prev.off + prev.sz;
  assign sum_pn   = sat_add(sum_pk, nxt.sz);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = OUT_W'({out_sz, out_off});
  assign m_tuser  = out_st;

  // Memory port control. Reads and writes in the same cycle always hit different entries:
  // a shift reads two places ahead of the entry it writes.
  always_comb begin
    mem_re = 1'b0;
    mem_ra = scan_ptr[IW-1:0];
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    case (state)
      S_SCAN: begin
        mem_re = (scan_ptr < count);
        mem_ra = scan_ptr[IW-1:0];
      end
      S_SHDN: begin
        mem_re = (sh_ptr < count);
        mem_ra = sh_ptr[IW-1:0];
        mem_we = rd_live;
        mem_wa = rd_idx - 1'b1;
        mem_wd = rd_data;
      end
      S_SHUP: begin
        mem_re = (sh_ptr > p);
        mem_ra = sh_dec[IW-1:0];
        mem_we = rd_live;
        mem_wa = rd_idx + 1'b1;
        mem_wd = rd_data;
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = p[IW-1:0];
        mem_wd = '{off: key_off, sz: key_sz};
      end
      S_SUM: begin
        mem_we = 1'b1;
        mem_wa = p_dec[IW-1:0];
        mem_wd = '{off: prev.off, sz: sum_pn};
      end
      S_CARVE: begin
        mem_we = (c_sz != c_amt);
        mem_wa = c_idx;
        mem_wd = '{off: c_off + c_amt, sz: c_sz - c_amt};
      end
      S_ACT: begin
        if (ins_op) begin
          if (tp && !tn) begin
            mem_we = 1'b1;
            mem_wa = p_dec[IW-1:0];
            mem_wd = '{off: prev.off, sz: sum_pk};
          end else if (!tp && tn) begin
            mem_we = 1'b1;
            mem_wa = p[IW-1:0];
            mem_wd = '{off: key_off, sz: sum_kn};
          end else if (!tp && !tn && full && op == OP_RELOC) begin
            // The old block cannot be returned: put the carved extent back as it was.
            mem_we = 1'b1;
            mem_wa = best_idx;
            mem_wd = best;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
    rd_idx <= mem_ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      rd_live  <= 1'b0;
    end else begin
      rd_live <= mem_re;
      // In S_OUT the output register is reloaded below instead.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            blk_off <= in_off;
            blk_sz  <= in_sz;
            req     <= in_req;
            key_off <= in_off;
            key_sz  <= in_sz;
            inc     <= in_req - in_sz;
            res_off <= '0;
            res_sz  <= '0;
            res_st  <= ST_OK;
            case (in_mode)
              MODE_INSERT: begin
                if (in_sz == '0) begin
                  state <= S_OUT;
                end else begin
                  op    <= OP_INS;
                  state <= S_PREP;
                end
              end
              MODE_ALLOC: begin
                if (in_req == '0) begin
                  state <= S_OUT;
                end else begin
                  op    <= OP_ALLOC;
                  state <= S_PREP;
                end
              end
              MODE_RESIZE: begin
                if (in_req == in_sz) begin
                  res_off <= in_off;
                  res_sz  <= in_sz;
                  state   <= S_OUT;
                end else if (in_req < in_sz) begin
                  // Shrink: the tail goes back to the list.
                  op      <= OP_SHRINK;
                  key_off <= in_off + in_req;
                  key_sz  <= in_sz - in_req;
                  state   <= S_PREP;
                end else begin
                  op    <= OP_GROW;
                  state <= S_PREP;
                end
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end

        S_PREP: begin
          key_end  <= key_off + key_sz;
          scan_ptr <= '0;
          found    <= 1'b0;
          p        <= count;
          if (op != OP_RELOC) begin
            best_found <= 1'b0;
          end
          state <= S_SCAN;
        end

        S_SCAN: begin
          if (mem_re) begin
            scan_ptr <= scan_ptr + 1'b1;
          end
          if (rd_live) begin
            if (!found) begin
              if (rd_data.off <= key_off) begin
                prev <= rd_data;
              end else begin
                found <= 1'b1;
                p     <= CW'(rd_idx);
                nxt   <= rd_data;
              end
            end
            if (op != OP_RELOC && rd_data.sz >= req && (!best_found || rd_data.sz < best.sz)) begin
              best_found <= 1'b1;
              best_idx   <= rd_idx;
              best       <= rd_data;
            end
          end else if (!mem_re) begin
            state <= S_TOUCH;
          end
        end

        S_TOUCH: begin
          tp     <= (p != '0) && (prev_end == key_off);
          tn     <= (p < count) && (nxt.off == key_end);
          gfit   <= (nxt.sz >= inc);
          sum_pk <= sat_add(prev.sz, key_sz);
          sum_kn <= sat_add(key_sz, nxt.sz);
          state  <= S_ACT;
        end

        S_ACT: begin
          case (op)
            OP_ALLOC: begin
              if (!best_found) begin
                res_st <= ST_NOFIT;
                state  <= S_OUT;
              end else begin
                res_off   <= best.off;
                res_sz    <= req;
                c_idx     <= best_idx;
                c_off     <= best.off;
                c_sz      <= best.sz;
                c_amt     <= req;
                done_next <= S_OUT;
                state     <= S_CARVE;
              end
            end
            OP_GROW: begin
              if (tn && gfit) begin
                // The next free extent touches the block and covers the increase.
                res_off   <= blk_off;
                res_sz    <= req;
                c_idx     <= p[IW-1:0];
                c_off     <= nxt.off;
                c_sz      <= nxt.sz;
                c_amt     <= inc;
                done_next <= S_OUT;
                state     <= S_CARVE;
              end else if (!best_found) begin
                res_st <= ST_NOFIT;
                state  <= S_OUT;
              end else begin
                // Relocate: carve the new block, then return the old one. An empty old
                // block has nothing to return, so the request ends after the carve.
                op        <= OP_RELOC;
                res_off   <= best.off;
                res_sz    <= req;
                c_idx     <= best_idx;
                c_off     <= best.off;
                c_sz      <= best.sz;
                c_amt     <= req;
                done_next <= (blk_sz == '0) ? S_OUT : S_PREP;
                state     <= S_CARVE;
              end
            end
            default: begin
              if (op == OP_SHRINK) begin
                res_off <= blk_off;
                res_sz  <= req;
              end else if (op == OP_RELOC) begin
                res_off <= best.off;
                res_sz  <= req;
              end
              if (tp) begin
                if (tn) begin
                  state <= S_SUM;
                end else begin
                  if (op == OP_INS) begin
                    res_off <= prev.off;
                    res_sz  <= sum_pk;
                  end
                  state <= S_OUT;
                end
              end else if (tn) begin
                if (op == OP_INS) begin
                  res_off <= key_off;
                  res_sz  <= sum_kn;
                end
                state <= S_OUT;
              end else if (full) begin
                res_off <= '0;
                res_sz  <= '0;
                res_st  <= ST_FULL;
                state   <= S_OUT;
              end else begin
                if (op == OP_INS) begin
                  res_off <= key_off;
                  res_sz  <= key_sz;
                end
                sh_ptr <= count;
                state  <= S_SHUP;
              end
            end
          endcase
        end

        S_SUM: begin
          // Merged with both neighbors: the following entry disappears.
          if (op == OP_INS) begin
            res_off <= prev.off;
            res_sz  <= sum_pn;
          end
          sh_ptr    <= p + 1'b1;
          done_next <= S_OUT;
          state     <= S_SHDN;
        end

        S_CARVE: begin
          if (c_sz == c_amt) begin
            sh_ptr <= CW'(c_idx) + 1'b1;
            state  <= S_SHDN;
          end else begin
            state <= done_next;
          end
        end

        S_SHDN: begin
          if (mem_re) begin
            sh_ptr <= sh_ptr + 1'b1;
          end else if (!rd_live) begin
            count <= count - 1'b1;
            state <= done_next;
          end
        end

        S_SHUP: begin
          if (mem_re) begin
            sh_ptr <= sh_dec;
          end else if (!rd_live) begin
            state <= S_PUT;
          end
        end

        S_PUT: begin
          count <= count + 1'b1;
          state <= S_OUT;
        end

        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_off  <= res_off;
            out_sz   <= res_sz;
            out_st   <= res_st;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/efla_checker.sv */
// Port-level assertions for the extent free-list allocator, bound to its top level.
// Depends on efla_pkg and extent_free_list_allocator.
module efla_props
  import efla_pkg::*;
#(
  parameter int EXTENT_BITS = EXTENT_BITS_DEF,
  localparam int OUT_W = ((2 * EXTENT_BITS + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_W-1:0]    m_tdata,
  input logic [STATUS_W-1:0] m_tuser
);

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Any failing request reports a zero offset and size.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("failed request carries nonzero data");

  // Requests are worked on one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in progress");

  // Reset leaves the block idle with no pending result.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind extent_free_list_allocator efla_props #(.EXTENT_BITS(EXTENT_BITS)) u_efla_props (.*);

/* dv/efla_checker.sv */
// Checker for the extent free-list allocator: watches both stream channels, keeps its own
// copy of the free list, predicts each result and compares it field by field.
// Depends on efla_pkg.
`timescale 1ns / 1ps
module efla_checker
  import efla_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int EB    = 62,
  parameter int IN_W  = 192,
  parameter int OUT_W = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,
  input  logic [MODE_W-1:0]   s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OUT_W-1:0]    m_tdata,
  input  logic [STATUS_W-1:0] m_tuser,
  output int                  errors,
  output int                  pending,
  output int                  free_count
);
  typedef logic [EB-1:0] ext_t;
  typedef struct packed {
    ext_t                  offs;
    ext_t                  size;
    logic [STATUS_W-1:0]   status;
  } grant_t;

  localparam ext_t EMAX = '1;

  ext_t   list_off[DEPTH];
  ext_t   list_size[DEPTH];
  int     list_n;
  grant_t grants_due[$];

  assign pending    = grants_due.size();
  assign free_count = list_n;

  function automatic ext_t sat_sum(ext_t a, ext_t b);
    logic [EB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EB] ? EMAX : s[EB-1:0];
  endfunction

  function automatic void drop_entry(int i);
    for (int k = i; k < list_n - 1; k++) begin
      list_off[k]  = list_off[k+1];
      list_size[k] = list_size[k+1];
    end
    list_n--;
  endfunction

  // Adds free space, merging with neighbours that touch it exactly.
  function automatic logic [STATUS_W-1:0] add_free(ext_t o, ext_t sz, output ext_t ro,
                                                   output ext_t rs);
    int   p, i;
    logic tp, tn;
    ext_t e;
    p  = 0;
    ro = '0;
    rs = '0;
    if (sz == 0) return ST_OK;
    while (p < list_n && list_off[p] <= o) p++;
    e  = o + sz;
    tp = p > 0 && ext_t'(list_off[p-1] + list_size[p-1]) == o;
    tn = p < list_n && list_off[p] == e;
    if (tp) begin
      i = p - 1;
      list_size[i] = sat_sum(list_size[i], sz);
      if (tn) begin
        list_size[i] = sat_sum(list_size[i], list_size[p]);
        drop_entry(p);
      end
    end else if (tn) begin
      i = p;
      list_off[i]  = o;
      list_size[i] = sat_sum(sz, list_size[i]);
    end else begin
      if (list_n >= DEPTH) return ST_FULL;
      for (int k = list_n; k > p; k--) begin
        list_off[k]  = list_off[k-1];
        list_size[k] = list_size[k-1];
      end
      list_off[p]  = o;
      list_size[p] = sz;
      list_n++;
      i = p;
    end
    ro = list_off[i];
    rs = list_size[i];
    return ST_OK;
  endfunction

  function automatic int smallest_fit(ext_t req);
    int b;
    b = -1;
    for (int i = 0; i < list_n; i++)
      if (list_size[i] >= req && (b < 0 || list_size[i] < list_size[b])) b = i;
    return b;
  endfunction

  function automatic void take_front(int i, ext_t req);
    list_off[i]  = list_off[i] + req;
    list_size[i] = list_size[i] - req;
    if (list_size[i] == 0) drop_entry(i);
  endfunction

  function automatic grant_t serve(logic [MODE_W-1:0] mode, ext_t bo, ext_t bs, ext_t rq);
    grant_t g;
    ext_t   t0, t1, inc;
    ext_t   sv_off[DEPTH];
    ext_t   sv_size[DEPTH];
    int     sv_n, b, p;
    g = '0;
    g.status = ST_OK;
    if (mode == MODE_INSERT) begin
      g.status = add_free(bo, bs, g.offs, g.size);
    end else if (mode == MODE_ALLOC) begin
      if (rq != 0) begin
        b = smallest_fit(rq);
        if (b < 0) g.status = ST_NOFIT;
        else begin
          g.offs = list_off[b];
          g.size = rq;
          take_front(b, rq);
        end
      end
    end else if (mode == MODE_RESIZE) begin
      if (rq == bs) begin
        g.offs = bo;
        g.size = bs;
      end else if (rq < bs) begin
        g.status = add_free(bo + rq, bs - rq, t0, t1);
        g.offs = bo;
        g.size = rq;
      end else begin
        inc = rq - bs;
        p = 0;
        while (p < list_n && list_off[p] <= bo) p++;
        if (p < list_n && ext_t'(bo + bs) == list_off[p] && list_size[p] >= inc) begin
          take_front(p, inc);
          g.offs = bo;
          g.size = rq;
        end else begin
          b = smallest_fit(rq);
          if (b < 0) g.status = ST_NOFIT;
          else begin
            sv_off  = list_off;
            sv_size = list_size;
            sv_n    = list_n;
            t0 = list_off[b];
            take_front(b, rq);
            g.status = add_free(bo, bs, t1, t1);
            if (g.status != ST_OK) begin
              list_off  = sv_off;
              list_size = sv_size;
              list_n    = sv_n;
            end else begin
              g.offs = t0;
              g.size = rq;
            end
          end
        end
      end
    end
    if (g.status != ST_OK) begin
      g.offs = '0;
      g.size = '0;
    end
    return g;
  endfunction

  task automatic report(string what, logic [EB-1:0] got, logic [EB-1:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    grant_t g, w;
    if (rst) begin
      list_n = 0;
      grants_due.delete();
    end else begin
      // The result side is checked first; a request and its own result never share an edge.
      if (m_tvalid && m_tready) begin
        g.offs   = m_tdata[EB-1:0];
        g.size   = m_tdata[2*EB-1:EB];
        g.status = m_tuser;
        if (grants_due.size() == 0) report("unexpected transfer", g.offs, '0);
        else begin
          w = grants_due.pop_front();
          if (g.offs !== w.offs) report("granted_offset", g.offs, w.offs);
          if (g.size !== w.size) report("granted_size", g.size, w.size);
          if (g.status !== w.status) report("status", EB'(g.status), EB'(w.status));
        end
      end
      if (s_tvalid && s_tready)
        grants_due.insert(grants_due.size(), serve(s_tuser, s_tdata[EB-1:0],
                                                   s_tdata[2*EB-1:EB],
                                                   s_tdata[3*EB-1:2*EB]));
    end
  end
endmodule

/* dv/testbench.sv */
// Top of the extent free-list allocator testbench: clock, reset, request stimulus, result
// stall pattern and the verdict. Depends on efla_pkg, efla_checker and the block itself.
`timescale 1ns / 1ps
module testbench;
  import efla_pkg::*;

  localparam int DEPTH = 64;
  localparam int EB    = 62;
  localparam int IN_W  = ((3 * EB + 7) / 8) * 8;
  localparam int OUT_W = ((2 * EB + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef logic [EB-1:0] ext_t;

  logic                clk = 0;
  logic                rst = 1;
  logic                s_tvalid = 0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic [MODE_W-1:0]   s_tuser = MODE_INSERT;
  logic                m_tvalid;
  logic                m_tready = 0;
  logic [OUT_W-1:0]    m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  int                  errors, pending, free_count;
  int                  idle_cycles = 0;
  bit                  hold_req = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  extent_free_list_allocator #(.LIST_DEPTH(DEPTH), .EXTENT_BITS(EB)) i_dut (.*);

  efla_checker #(.DEPTH(DEPTH), .EB(EB), .IN_W(IN_W), .OUT_W(OUT_W)) i_checker (.*);

  // The result side stalls on its own pattern: runs of readiness and runs of stalls, with
  // long stretches of readiness. When a hold-off is requested, it refuses results until
  // its HOLD_CYCLES count runs out and then clears the request.
  initial begin
    int run;
    @(posedge clk iff !rst);
    forever begin
      if (hold_req) begin
        m_tready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      run = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 6);
      for (int k = 0; k < run; k++) begin
        m_tready <= (run > 20 || $urandom_range(0, 2) != 0);
        @(posedge clk);
      end
    end
  end

  // Cycles with no transfer on either side end the run once they reach the limit.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("extent_free_list_allocator test failed");
      $finish;
    end
  end

  int gap_left = 0;

  // One request transfer. Between bursts the sender drops tvalid for a random gap.
  task automatic send(logic [MODE_W-1:0] mode, ext_t bo, ext_t bs, ext_t rq);
    if (gap_left == 0 && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap_left = $urandom_range(1, 20);
    end
    if (gap_left > 0) gap_left--;
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= IN_W'({rq, bs, bo});
    @(posedge clk iff s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk iff pending == 0);
  endtask

  function automatic ext_t small_val(int hi);
    return ext_t'($urandom_range(0, hi));
  endfunction

  function automatic ext_t wide_val();
    return ext_t'({$urandom(), $urandom()});
  endfunction

  initial begin
    ext_t bo, bs, rq;
    int   sel, done_items;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero sizes, a fresh extent, exact fit, no fit, neighbours merging on both
    // sides, a saturating merge at the top of the range, resizes that keep, shrink, relocate or do not fit, and mode 3.
    send(MODE_INSERT, 100, 0, 0);
    send(MODE_ALLOC, 0, 0, 0);
    send(MODE_ALLOC, 0, 0, 5);
    send(MODE_INSERT, 100, 50, 0);
    send(MODE_INSERT, 200, 20, 0);
    send(MODE_INSERT, 150, 50, 0);
    send(MODE_INSERT, 80, 20, 0);
    send(MODE_ALLOC, 0, 0, 140);
    send(MODE_ALLOC, 0, 0, 500);
    send(MODE_INSERT, 300, 10, 0);
    send(MODE_INSERT, 320, 30, 0);
    send(MODE_ALLOC, 0, 0, 10);
    send(MODE_RESIZE, 220, 10, 10);
    send(MODE_RESIZE, 220, 10, 4);
    send(MODE_RESIZE, 80, 140, 146);
    send(MODE_RESIZE, 0, 10, 20);
    send(MODE_RESIZE, 1000, 5, 200000);
    send(MODE_RSVD, '1, '1, '1);
    send(MODE_INSERT, '1, '1, '1);
    send(MODE_INSERT, 1, '1, 0);
    send(MODE_INSERT, 0, 1, 0);
    send(MODE_ALLOC, 0, 0, '1);
    send(MODE_RESIZE, '1, '1, '1 - 1);
    drain();

    // The list is filled until it reports full while the result side holds off, so the
    // block backs up on its input; the sender then waits for every result.
    hold_req = 1;
    for (int k = 0; k < 70; k++) send(MODE_INSERT, ext_t'(5000 + 4 * k), 2, 0);
    send(MODE_RESIZE, 5000, 2, 1);
    send(MODE_RESIZE, 6000, 2, 3);
    drain();

    // Random: mostly coherent traffic in a small address space so merges, fits and
    // relocations are frequent, with some wide-range noise that exercises every bit.
    done_items = 0;
    while (done_items < 700) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        bo = wide_val();
        bs = wide_val();
        rq = wide_val();
        send(MODE_W'($urandom_range(0, 3)), bo, bs, rq);
      end else if (sel < 45) begin
        send(MODE_INSERT, small_val(4000), small_val(60), small_val(3));
      end else if (sel < 75) begin
        send(MODE_ALLOC, small_val(5), small_val(5), small_val(80));
      end else begin
        send(MODE_RESIZE, small_val(4000), small_val(60), small_val(90));
      end
      done_items++;
      if (done_items % 250 == 0) drain();
      if (free_count > 50 && $urandom_range(0, 3) == 0) begin
        drain();
        repeat (20) begin
          send(MODE_ALLOC, 0, 0, small_val(30) + 1);
          done_items++;
        end
      end
    end
    drain();
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("extent_free_list_allocator test passed");
    end else begin
      $display("extent_free_list_allocator test failed");
    end
    $finish;
  end
endmodule
